FILE: rtl/core/qfuv_pkg.sv
// Shared constants, types and step functions of the shortest-arc quaternion unit.
package qfuv_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int LIM        = (ONE < 32767) ? ONE : 32767;
    localparam int DIV_STEPS  = 31;   // quotient bits kept; larger quotients saturate
    localparam int SQRT_STEPS = 16;   // root bits of a 32-bit radicand

    typedef enum logic [1:0] {
        CASE_GEN  = 2'd0,
        CASE_SAME = 2'd1,
        CASE_OPP  = 2'd2
    } t_case;

    // one lane of the restoring divider
    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] den;
        logic [30:0] xlo;
        logic [30:0] quo;
        logic        neg;
        logic        ovf;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0] ln;
        logic [29:0]     wrad;
        t_case           code;
        logic            zero;
    } t_div_st;

    // one lane of the digit-by-digit square root
    typedef struct packed {
        logic [18:0] rem;
        logic [15:0] root;
        logic [31:0] rad;
    } t_sq_lane;

    typedef struct packed {
        t_sq_lane [3:0] ln;
        logic [2:0]     neg;
        logic [2:0]     ovf;
        t_case          code;
        logic           zero;
    } t_sq_st;

    function automatic t_div_lane div_step(input t_div_lane a);
        t_div_lane   b;
        logic [31:0] trial;
        b       = a;
        trial   = {a.rem, a.xlo[30]};
        b.xlo   = {a.xlo[29:0], 1'b0};
        if (trial >= a.den) begin
            b.rem = 31'(trial - a.den);
            b.quo = {a.quo[29:0], 1'b1};
        end else begin
            b.rem = trial[30:0];
            b.quo = {a.quo[29:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_sq_lane sq_step(input t_sq_lane a);
        t_sq_lane    b;
        logic [18:0] cur;
        logic [18:0] trial;
        cur   = {a.rem[16:0], a.rad[31:30]};
        trial = {1'b0, a.root, 2'b01};
        b.rad = {a.rad[29:0], 2'b00};
        if (cur >= trial) begin
            b.rem  = cur - trial;
            b.root = {a.root[14:0], 1'b1};
        end else begin
            b.rem  = cur;
            b.root = {a.root[14:0], 1'b0};
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/quat_from_unit_vectors_unit.sv
// Shortest-arc rotation quaternion between two Q1.14 unit vectors, fully pipelined.
//
// Each input word carries a source and a target vector (signed Q1.14); each output
// word carries the quaternion (w unsigned, x/y/z signed, Q1.14), a case code
// (general, same direction, opposite) and a saturation flag. The unit takes one
// word per clock while the output side does not stall and returns one word per
// input word, in order. The pipeline is made of the front end (input capture,
// the 16x16 products, the dot/cross sums, case selection and the 32x32 squaring:
// five registers), the restoring divider (a load register and 31 stages, one
// quotient bit per stage), the square-root pipeline (a load register and 16
// stages, one root bit per stage) and the output register. Each vector part is
// round(sqrt(c^2*2^k/M))
// with the sign of its numerator; quotients of 2^31 or more saturate to the
// limit. A stall on the output holds the whole pipeline; the input register can
// still take one more word while the output waits. Results are bit exact for any
// 16-bit input pattern, including non-unit vectors.
module quat_from_unit_vectors_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_src_x,
    input  logic signed [15:0] i_src_y,
    input  logic signed [15:0] i_src_z,
    input  logic signed [15:0] i_dst_x,
    input  logic signed [15:0] i_dst_y,
    input  logic signed [15:0] i_dst_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [14:0]        o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic [1:0]         o_case_code,
    output logic               o_saturated
);

    localparam logic signed [33:0] ONE2  = 34'sd1 <<< (2 * qfuv_pkg::FRAC_BITS);
    localparam logic [15:0]        LIM16 = 16'(qfuv_pkg::LIM);
    localparam logic [15:0]        ONE16 = 16'(qfuv_pkg::ONE);

    // pipeline advance; the whole pipe moves together behind the output register
    logic en;
    assign en      = ~o_valid | i_ready;
    // input register takes a word whenever the pipe moves or it is empty
    logic r_v0;
    assign o_ready = en | ~r_v0;

    // ---- stage 0: input capture
    logic signed [15:0] r_src [3];
    logic signed [15:0] r_dst [3];

    // ---- stage B: products
    logic               r_vb;
    logic signed [31:0] r_pd   [3];   // src_i * dst_i
    logic signed [31:0] r_pc   [6];   // cross terms
    logic signed [31:0] r_ps   [3];   // src_i squared
    logic signed [15:0] r_srcb [3];

    // ---- stage C: sums
    logic               r_vc;
    logic signed [33:0] r_dot;
    logic signed [32:0] r_crs  [3];
    logic [31:0]        r_n2a, r_n2b;
    logic signed [15:0] r_srcc [3];

    // ---- stage D: case selection
    logic               r_vd;
    logic [31:0]        r_mag  [3];
    logic [2:0]         r_negd;
    logic [31:0]        r_den;
    logic [29:0]        r_wrad;
    qfuv_pkg::t_case    r_code;
    logic               r_zero;

    // ---- stage E: squared numerators
    logic               r_ve;
    logic [63:0]        r_msq  [3];
    logic [2:0]         r_nege;
    logic [31:0]        r_dene;
    logic [29:0]        r_wrade;
    qfuv_pkg::t_case    r_codee;
    logic               r_zeroe;

    // ---- divider and root pipelines
    qfuv_pkg::t_div_st r_div [qfuv_pkg::DIV_STEPS + 1];
    logic              r_dv  [qfuv_pkg::DIV_STEPS + 1];
    qfuv_pkg::t_sq_st  r_sq  [qfuv_pkg::SQRT_STEPS + 1];
    logic              r_sv  [qfuv_pkg::SQRT_STEPS + 1];

    // ---- combinational stage logic
    logic signed [33:0] n_dot;
    logic signed [32:0] n_p [3];
    logic signed [33:0] n_e;
    qfuv_pkg::t_case    n_code;
    logic               n_zero;
    logic [31:0]        n_den;
    qfuv_pkg::t_div_st  n_div0;
    qfuv_pkg::t_sq_st   n_sq0;

    assign n_dot = 34'(r_pd[0]) + 34'(r_pd[1]) + 34'(r_pd[2]);
    assign n_e   = ONE2 + r_dot;

    always_comb begin
        n_code = qfuv_pkg::CASE_GEN;
        n_zero = 1'b0;
        n_den  = {3'b000, n_e[28:0]};
        n_p[0] = r_crs[0];
        n_p[1] = r_crs[1];
        n_p[2] = r_crs[2];
        if (r_dot >= ONE2) begin
            n_code = qfuv_pkg::CASE_SAME;
        end else if (r_dot <= -ONE2) begin
            n_code = qfuv_pkg::CASE_OPP;
            if (r_n2a != 32'd0) begin
                // axis = source x (1,0,0)
                n_p[0] = 33'sd0;
                n_p[1] = 33'(r_srcc[2]);
                n_p[2] = -33'(r_srcc[1]);
                n_den  = r_n2a;
            end else begin
                // axis = source x (0,1,0)
                n_p[0] = -33'(r_srcc[2]);
                n_p[1] = 33'sd0;
                n_p[2] = 33'(r_srcc[0]);
                n_den  = r_n2b;
                n_zero = (r_n2b == 32'd0);
            end
        end
    end

    // radicand x = msq * 2 (general) or msq * 2^30 (half turn), then quotient by den
    always_comb begin
        logic [63:0] x;
        n_div0 = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_codee == qfuv_pkg::CASE_OPP) begin
                x = {r_msq[i][33:0], 30'd0};
            end else begin
                x = {r_msq[i][62:0], 1'b0};
            end
            n_div0.ln[i].ovf = (x >= {1'b0, r_dene, 31'd0});
            n_div0.ln[i].rem = x[61:31];
            n_div0.ln[i].xlo = x[30:0];
            n_div0.ln[i].quo = '0;
            n_div0.ln[i].den = r_dene;
            n_div0.ln[i].neg = r_nege[i];
        end
        n_div0.wrad = r_wrade;
        n_div0.code = r_codee;
        n_div0.zero = r_zeroe;
    end

    always_comb begin
        n_sq0 = '0;
        for (int i = 0; i < 3; i++) begin
            n_sq0.ln[i].rad = {1'b0, r_div[qfuv_pkg::DIV_STEPS].ln[i].quo};
            n_sq0.ln[i].rem = '0;
            n_sq0.ln[i].root = '0;
            n_sq0.neg[i] = r_div[qfuv_pkg::DIV_STEPS].ln[i].neg;
            n_sq0.ovf[i] = r_div[qfuv_pkg::DIV_STEPS].ln[i].ovf;
        end
        n_sq0.ln[3].rad  = {2'b00, r_div[qfuv_pkg::DIV_STEPS].wrad};
        n_sq0.ln[3].rem  = '0;
        n_sq0.ln[3].root = '0;
        n_sq0.code = r_div[qfuv_pkg::DIV_STEPS].code;
        n_sq0.zero = r_div[qfuv_pkg::DIV_STEPS].zero;
    end

    // ---- output rounding, sign and clamp
    logic [16:0]        n_rnd [4];
    logic [15:0]        n_mag [4];
    logic [3:0]         n_sat;
    logic [14:0]        n_w;
    logic signed [15:0] n_v [3];
    logic               n_satout;

    always_comb begin
        qfuv_pkg::t_sq_st s;
        s = r_sq[qfuv_pkg::SQRT_STEPS];
        for (int i = 0; i < 4; i++) begin
            n_rnd[i] = {1'b0, s.ln[i].root} + 17'd1;
            n_sat[i] = (n_rnd[i][16:1] > LIM16) | ((i < 3) ? s.ovf[i[1:0]] : 1'b0);
            n_mag[i] = n_sat[i] ? LIM16 : n_rnd[i][16:1];
        end
        for (int i = 0; i < 3; i++) begin
            n_v[i] = s.neg[i] ? -$signed(n_mag[i]) : $signed(n_mag[i]);
        end
        n_w      = n_mag[3][14:0];
        n_satout = |n_sat;
        unique case (s.code)
            qfuv_pkg::CASE_SAME: begin
                n_w      = (ONE16 > LIM16) ? LIM16[14:0] : ONE16[14:0];
                n_v[0]   = '0;
                n_v[1]   = '0;
                n_v[2]   = '0;
                n_satout = (ONE16 > LIM16);
            end
            qfuv_pkg::CASE_OPP: begin
                n_w      = '0;
                n_satout = |n_sat[2:0];
                if (s.zero) begin
                    n_v[0]   = '0;
                    n_v[1]   = '0;
                    n_v[2]   = '0;
                    n_satout = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            r_ve    <= 1'b0;
            o_valid <= 1'b0;
            for (int k = 0; k <= qfuv_pkg::DIV_STEPS; k++) r_dv[k] <= 1'b0;
            for (int k = 0; k <= qfuv_pkg::SQRT_STEPS; k++) r_sv[k] <= 1'b0;
        end else begin
            if (o_ready) r_v0 <= i_valid;
            if (en) begin
                r_vb    <= r_v0;
                r_vc    <= r_vb;
                r_vd    <= r_vc;
                r_ve    <= r_vd;
                r_dv[0] <= r_ve;
                for (int k = 1; k <= qfuv_pkg::DIV_STEPS; k++) r_dv[k] <= r_dv[k-1];
                r_sv[0] <= r_dv[qfuv_pkg::DIV_STEPS];
                for (int k = 1; k <= qfuv_pkg::SQRT_STEPS; k++) r_sv[k] <= r_sv[k-1];
                o_valid <= r_sv[qfuv_pkg::SQRT_STEPS];
            end
        end
    end

    // ---- payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_src[0] <= i_src_x;
            r_src[1] <= i_src_y;
            r_src[2] <= i_src_z;
            r_dst[0] <= i_dst_x;
            r_dst[1] <= i_dst_y;
            r_dst[2] <= i_dst_z;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i]   <= r_src[i] * r_dst[i];
                r_ps[i]   <= r_src[i] * r_src[i];
                r_srcb[i] <= r_src[i];
            end
            r_pc[0] <= r_src[1] * r_dst[2];
            r_pc[1] <= r_src[2] * r_dst[1];
            r_pc[2] <= r_src[2] * r_dst[0];
            r_pc[3] <= r_src[0] * r_dst[2];
            r_pc[4] <= r_src[0] * r_dst[1];
            r_pc[5] <= r_src[1] * r_dst[0];

            r_dot    <= n_dot;
            r_crs[0] <= 33'(r_pc[0]) - 33'(r_pc[1]);
            r_crs[1] <= 33'(r_pc[2]) - 33'(r_pc[3]);
            r_crs[2] <= 33'(r_pc[4]) - 33'(r_pc[5]);
            r_n2a    <= 32'(r_ps[1]) + 32'(r_ps[2]);
            r_n2b    <= 32'(r_ps[2]) + 32'(r_ps[0]);
            for (int i = 0; i < 3; i++) r_srcc[i] <= r_srcb[i];

            for (int i = 0; i < 3; i++) begin
                r_negd[i] <= n_p[i][32];
                r_mag[i]  <= n_p[i][32] ? 32'(-n_p[i]) : n_p[i][31:0];
            end
            r_den  <= n_den;
            r_wrad <= {n_e[28:0], 1'b0};
            r_code <= n_code;
            r_zero <= n_zero;

            for (int i = 0; i < 3; i++) r_msq[i] <= r_mag[i] * r_mag[i];
            r_nege  <= r_negd;
            r_dene  <= r_den;
            r_wrade <= r_wrad;
            r_codee <= r_code;
            r_zeroe <= r_zero;

            r_div[0] <= n_div0;
            r_sq[0]  <= n_sq0;

            o_quat_w    <= n_w;
            o_quat_x    <= n_v[0];
            o_quat_y    <= n_v[1];
            o_quat_z    <= n_v[2];
            o_case_code <= r_sq[qfuv_pkg::SQRT_STEPS].code;
            o_saturated <= n_satout;
        end
    end

    // one quotient bit per divider stage
    for (genvar k = 1; k <= qfuv_pkg::DIV_STEPS; k++) begin : g_div
        qfuv_pkg::t_div_st n_div;
        always_comb begin
            n_div       = r_div[k-1];
            n_div.ln[0] = qfuv_pkg::div_step(r_div[k-1].ln[0]);
            n_div.ln[1] = qfuv_pkg::div_step(r_div[k-1].ln[1]);
            n_div.ln[2] = qfuv_pkg::div_step(r_div[k-1].ln[2]);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k] <= n_div;
            end
        end
    end

    // one root bit per square-root stage
    for (genvar k = 1; k <= qfuv_pkg::SQRT_STEPS; k++) begin : g_sq
        qfuv_pkg::t_sq_st n_sq;
        always_comb begin
            n_sq       = r_sq[k-1];
            n_sq.ln[0] = qfuv_pkg::sq_step(r_sq[k-1].ln[0]);
            n_sq.ln[1] = qfuv_pkg::sq_step(r_sq[k-1].ln[1]);
            n_sq.ln[2] = qfuv_pkg::sq_step(r_sq[k-1].ln[2]);
            n_sq.ln[3] = qfuv_pkg::sq_step(r_sq[k-1].ln[3]);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k] <= n_sq;
            end
        end
    end

    // ---- assertions
    a_same_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_case_code == qfuv_pkg::CASE_SAME |->
            o_quat_x == 16'sd0 && o_quat_y == 16'sd0 && o_quat_z == 16'sd0)
        else $error("identity word with nonzero vector part");

    a_opp_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_case_code == qfuv_pkg::CASE_OPP |-> o_quat_w == 15'd0)
        else $error("half-turn word with nonzero w");

    a_gen_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_case_code == qfuv_pkg::CASE_GEN |-> o_quat_w != 15'd0)
        else $error("general word with zero w");

    a_sat_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated && o_case_code == qfuv_pkg::CASE_GEN |->
            o_quat_x == $signed(LIM16) || o_quat_x == -$signed(LIM16) ||
            o_quat_y == $signed(LIM16) || o_quat_y == -$signed(LIM16) ||
            o_quat_z == $signed(LIM16) || o_quat_z == -$signed(LIM16))
        else $error("saturation flag without a clamped part");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && !en |=> r_v0)
        else $error("captured word lost during stall");

endmodule
